// ===== rtl/fdk_pkg.sv =====
// Shared types and constants for the fan drive with start kick block.
package fdk_pkg;

    localparam int TEMP_W    = 15;
    localparam int PCT_W     = 7;
    localparam int DUTY_W    = 8;
    localparam int SECS_W    = 16;
    localparam int KICK_W    = 2;
    localparam int CFG_W     = 15;
    localparam int CFG_IDX_W = 2;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 32;

    localparam logic [DUTY_W-1:0] KICK_DUTY    = 8'd255;
    localparam logic [PCT_W-1:0]  FULL_PERCENT = 7'd100;
    localparam logic [KICK_W-1:0] KICK_LENGTH  = 2'd2;

    // Division by 100 of values up to 25500: (x * 41944) >> 22 is exact there.
    localparam int RECIP_SHIFT = 22;
    localparam logic [15:0] RECIP_100 = 16'd41944;

    localparam logic signed [TEMP_W-1:0] HEATER_MIN_RESET = 15'sd3000;
    localparam logic signed [TEMP_W-1:0] ROOM_MIN_RESET   = 15'sd2000;
    localparam logic [DUTY_W-1:0]        PWM_MIN_RESET    = 8'd0;
    localparam logic [DUTY_W-1:0]        PWM_MAX_RESET    = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEATER_MIN = 2'd0,
        REG_ROOM_MIN   = 2'd1,
        REG_PWM_MIN    = 2'd2,
        REG_PWM_MAX    = 2'd3
    } reg_idx_t;

    typedef enum logic {
        CMD_TICK     = 1'b0,
        CMD_OVERRIDE = 1'b1
    } cmd_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] heater_min_centi;
        logic signed [TEMP_W-1:0] room_min_centi;
        logic [DUTY_W-1:0]        pwm_min;
        logic [DUTY_W-1:0]        pwm_max;
    } cfg_t;

endpackage

// ===== rtl/fdk_request.sv =====
// Automatic fan power request from heater and room temperatures.
module fdk_request (
    input  fdk_pkg::cfg_t                            cfg,
    input  logic signed [fdk_pkg::TEMP_W-1:0]        heater_temp,
    input  logic signed [fdk_pkg::TEMP_W-1:0]        room_temp,
    output logic [fdk_pkg::PCT_W-1:0]                auto_request
);

    logic signed [fdk_pkg::TEMP_W:0] room_min_ext;
    logic signed [fdk_pkg::TEMP_W:0] room_ext;
    logic signed [fdk_pkg::TEMP_W:0] bound;
    logic signed [fdk_pkg::TEMP_W:0] diff;

    assign room_min_ext = {cfg.room_min_centi[fdk_pkg::TEMP_W-1], cfg.room_min_centi};
    assign room_ext     = {room_temp[fdk_pkg::TEMP_W-1], room_temp};
    assign bound        = room_min_ext - $signed({{(fdk_pkg::TEMP_W+1-fdk_pkg::PCT_W){1'b0}},
                                                  fdk_pkg::FULL_PERCENT});
    assign diff         = room_min_ext - room_ext;

    always_comb begin
        if (heater_temp < cfg.heater_min_centi) begin
            auto_request = '0;
        end else if (room_ext < bound) begin
            auto_request = fdk_pkg::FULL_PERCENT;
        end else if (room_ext > room_min_ext) begin
            auto_request = '0;
        end else begin
            // Here the difference lies between 0 and 100.
            auto_request = diff[fdk_pkg::PCT_W-1:0];
        end
    end

endmodule

// ===== rtl/fan_drive_with_kick_start_core.sv =====
// Top level of the fan drive with start kick block.
//
// Usage: each transfer on the s_ channel carries either a one second tick with
// heater and room readings (s_tuser low) or a manual override load (s_tuser
// high). A tick yields one transfer on the m_ channel with the power request,
// the fan duty, the kick flag and the override ticks left; an override load
// yields no result and only sets the override state.
// The four setup registers are written through cfg_wr_en, cfg_addr and
// cfg_wdata while the block is idle.
// An accepted tick passes two registered stages on the way to the m_ side:
// the first stage evaluates the request, updates the kick and override state
// and forms request times duty span; the second scales that product by a
// reciprocal multiply and registers the duty. One item is accepted per cycle
// while the receiver keeps up. When the receiver stalls, the two stages fill
// and s_tready falls; it rises again as soon as a result is taken. Reset clears
// the pipeline, the kick and override state and loads the register defaults.
module fan_drive_with_kick_start_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // heater_temp[14:0], room_temp[29:15], override_seconds[45:30],
    // override_percent[52:46], zero fill [55:53]
    input  logic [fdk_pkg::S_TDATA_W-1:0]     s_tdata,
    // command[0]
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // power_request[6:0], pwm_duty[14:7], kick_active[15], override_left[31:16]
    output logic [fdk_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [fdk_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [fdk_pkg::CFG_W-1:0]         cfg_wdata
);

    fdk_pkg::cfg_t cfg_reg;

    logic [fdk_pkg::KICK_W-1:0] kick_left_reg;
    logic [fdk_pkg::KICK_W-1:0] kick_left_next;
    logic [fdk_pkg::PCT_W-1:0]  last_req_reg;
    logic [fdk_pkg::PCT_W-1:0]  last_req_next;
    logic [fdk_pkg::SECS_W-1:0] manual_left_reg;
    logic [fdk_pkg::SECS_W-1:0] manual_left_next;
    logic [fdk_pkg::PCT_W-1:0]  manual_pct_reg;
    logic [fdk_pkg::PCT_W-1:0]  manual_pct_next;

    logic s1_valid_reg;
    logic [fdk_pkg::PCT_W-1:0]  s1_req_reg;
    logic                       s1_kick_reg;
    logic [fdk_pkg::SECS_W-1:0] s1_left_reg;
    logic signed [15:0]         s1_prod_reg;

    logic m_valid_reg;
    logic [fdk_pkg::M_TDATA_W-1:0] m_data_reg;
    logic [fdk_pkg::M_TDATA_W-1:0] m_data_next;

    logic out_ready;
    logic s1_ready;
    logic s_accept;

    logic signed [fdk_pkg::TEMP_W-1:0] heater_temp;
    logic signed [fdk_pkg::TEMP_W-1:0] room_temp;
    logic [fdk_pkg::SECS_W-1:0]        override_seconds;
    logic [fdk_pkg::PCT_W-1:0]         override_percent;
    logic                              is_tick;

    logic [fdk_pkg::PCT_W-1:0]  auto_req;
    logic                       manual_on;
    logic [fdk_pkg::PCT_W-1:0]  req;
    logic [fdk_pkg::SECS_W-1:0] left;
    logic                       kick_start;
    logic [fdk_pkg::KICK_W-1:0] kick_eff;
    logic                       kick_now;
    logic signed [8:0]          span;
    logic signed [15:0]         prod;

    logic [14:0]                prod_abs;
    logic [30:0]                scaled;
    logic [fdk_pkg::DUTY_W-1:0] quot;
    logic [fdk_pkg::DUTY_W-1:0] duty;

    assign heater_temp      = s_tdata[14:0];
    assign room_temp        = s_tdata[29:15];
    assign override_seconds = s_tdata[45:30];
    assign override_percent = s_tdata[52:46];
    assign is_tick          = (s_tuser == fdk_pkg::CMD_TICK);

    assign out_ready = !m_valid_reg || m_tready;
    assign s1_ready  = !s1_valid_reg || out_ready;
    assign s_tready  = s1_ready;
    assign s_accept  = s_tvalid && s1_ready;

    fdk_request u_request (
        .cfg          (cfg_reg),
        .heater_temp  (heater_temp),
        .room_temp    (room_temp),
        .auto_request (auto_req)
    );

    // First stage: request selection, override load and countdown, kick decision and request times span.
    always_comb begin
        manual_on  = (manual_left_reg != '0);
        req        = manual_on ? manual_pct_reg : auto_req;
        left       = manual_on ? manual_left_reg - 1'b1 : manual_left_reg;
        kick_start = (kick_left_reg == '0) && (req != last_req_reg) && (req != '0);
        kick_eff   = kick_start ? fdk_pkg::KICK_LENGTH : kick_left_reg;
        kick_now   = (kick_eff != '0);
        span       = $signed({1'b0, cfg_reg.pwm_max}) - $signed({1'b0, cfg_reg.pwm_min});
        prod       = 16'($signed({1'b0, req}) * span);

        kick_left_next   = kick_left_reg;
        last_req_next    = last_req_reg;
        manual_left_next = manual_left_reg;
        manual_pct_next  = manual_pct_reg;
        if (s_accept) begin
            if (is_tick) begin
                kick_left_next   = kick_now ? kick_eff - 1'b1 : '0;
                last_req_next    = kick_start ? req : last_req_reg;
                manual_left_next = left;
            end else begin
                manual_left_next = override_seconds;
                manual_pct_next  = (override_percent > fdk_pkg::FULL_PERCENT) ?
                                   fdk_pkg::FULL_PERCENT : override_percent;
            end
        end
    end

    // Second stage: duty = pwm_min + product / 100, truncated toward zero; a kick gives full duty, a zero request zero.
    always_comb begin
        prod_abs = s1_prod_reg[15] ? 15'(-s1_prod_reg) : s1_prod_reg[14:0];
        scaled   = 31'(prod_abs * fdk_pkg::RECIP_100);
        quot     = scaled[fdk_pkg::RECIP_SHIFT +: fdk_pkg::DUTY_W];
        if (s1_kick_reg) begin
            duty = fdk_pkg::KICK_DUTY;
        end else if (s1_req_reg == '0) begin
            duty = '0;
        end else if (s1_prod_reg[15]) begin
            duty = cfg_reg.pwm_min - quot;
        end else begin
            duty = cfg_reg.pwm_min + quot;
        end
        m_data_next = {s1_left_reg, s1_kick_reg, duty, s1_req_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.heater_min_centi <= fdk_pkg::HEATER_MIN_RESET;
            cfg_reg.room_min_centi   <= fdk_pkg::ROOM_MIN_RESET;
            cfg_reg.pwm_min          <= fdk_pkg::PWM_MIN_RESET;
            cfg_reg.pwm_max          <= fdk_pkg::PWM_MAX_RESET;
        end else if (cfg_wr_en) begin
            case (fdk_pkg::reg_idx_t'(cfg_addr))
                fdk_pkg::REG_HEATER_MIN: cfg_reg.heater_min_centi <= cfg_wdata;
                fdk_pkg::REG_ROOM_MIN:   cfg_reg.room_min_centi   <= cfg_wdata;
                fdk_pkg::REG_PWM_MIN:    cfg_reg.pwm_min <= cfg_wdata[fdk_pkg::DUTY_W-1:0];
                fdk_pkg::REG_PWM_MAX:    cfg_reg.pwm_max <= cfg_wdata[fdk_pkg::DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kick_left_reg   <= '0;
            last_req_reg    <= '0;
            manual_left_reg <= '0;
            manual_pct_reg  <= '0;
            s1_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            kick_left_reg   <= kick_left_next;
            last_req_reg    <= last_req_next;
            manual_left_reg <= manual_left_next;
            manual_pct_reg  <= manual_pct_next;
            // An override load advances through the state only, never the pipeline.
            if (s1_ready) begin
                s1_valid_reg <= s_accept && is_tick;
            end
            if (out_ready) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready) begin
            s1_req_reg  <= req;
            s1_kick_reg <= kick_now;
            s1_left_reg <= left;
            s1_prod_reg <= prod;
        end
        if (out_ready && s1_valid_reg) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== dv/fan_duty_checker.sv =====
// Checker for the fan drive: predicts every tick result and compares it with the m_ channel.
module fan_duty_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [fdk_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [fdk_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            cfg_wr_en,
    input  logic [fdk_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [fdk_pkg::CFG_W-1:0]       cfg_wdata,
    output int                              outstanding,
    output int                              fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [fdk_pkg::PCT_W-1:0]  power_request;
        logic [fdk_pkg::DUTY_W-1:0] pwm_duty;
        logic                       kick_active;
        logic [fdk_pkg::SECS_W-1:0] override_left;
    } fan_result_t;

    fan_result_t expected_fan_q[$];

    // Own copy of the setup registers and of the drive state.
    logic signed [fdk_pkg::TEMP_W-1:0] heater_floor;
    logic signed [fdk_pkg::TEMP_W-1:0] room_floor;
    logic [fdk_pkg::DUTY_W-1:0]        duty_lo;
    logic [fdk_pkg::DUTY_W-1:0]        duty_hi;
    logic [fdk_pkg::KICK_W-1:0]        kick_count;
    logic [fdk_pkg::PCT_W-1:0]         kicked_percent;
    logic [fdk_pkg::SECS_W-1:0]        manual_count;
    logic [fdk_pkg::PCT_W-1:0]         manual_level;

    task automatic report_error(input string msg);
        $display("%0t ns: %s", $time, msg);
        fail_count++;
    endtask

    // Advances the drive state by one tick and returns what the block must show for it.
    function automatic fan_result_t run_fan_tick(
        input logic signed [fdk_pkg::TEMP_W-1:0] heater,
        input logic signed [fdk_pkg::TEMP_W-1:0] room);
        fan_result_t res;
        int          percent;
        int          span;
        int          duty;
        if (heater < heater_floor) begin
            percent = 0;
        end else if (int'(room) < int'(room_floor) - 100) begin
            percent = 100;
        end else if (room > room_floor) begin
            percent = 0;
        end else begin
            percent = int'(room_floor) - int'(room);
        end
        if (manual_count != 0) begin
            manual_count--;
            percent = manual_level;
        end
        // A new nonzero request starts a kick only once the previous kick is over.
        if (kick_count == 0 && percent != int'(kicked_percent) && percent != 0) begin
            kick_count     = fdk_pkg::KICK_LENGTH;
            kicked_percent = 7'(percent);
        end
        res.kick_active = 1'b0;
        if (kick_count != 0) begin
            kick_count--;
            duty            = fdk_pkg::KICK_DUTY;
            res.kick_active = 1'b1;
        end else if (percent == 0) begin
            duty = 0;
        end else begin
            span = int'(duty_hi) - int'(duty_lo);
            duty = int'(duty_lo) + (percent * span) / 100;
        end
        res.power_request = 7'(percent);
        res.pwm_duty      = 8'(duty);
        res.override_left = manual_count;
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        fan_result_t got;
        fan_result_t want;
        logic [fdk_pkg::PCT_W-1:0] level;
        if (!aresetn) begin
            heater_floor   = fdk_pkg::HEATER_MIN_RESET;
            room_floor     = fdk_pkg::ROOM_MIN_RESET;
            duty_lo        = fdk_pkg::PWM_MIN_RESET;
            duty_hi        = fdk_pkg::PWM_MAX_RESET;
            kick_count     = '0;
            kicked_percent = '0;
            manual_count   = '0;
            manual_level   = '0;
            expected_fan_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    fdk_pkg::REG_HEATER_MIN: heater_floor = cfg_wdata;
                    fdk_pkg::REG_ROOM_MIN:   room_floor   = cfg_wdata;
                    fdk_pkg::REG_PWM_MIN:    duty_lo      = cfg_wdata[fdk_pkg::DUTY_W-1:0];
                    fdk_pkg::REG_PWM_MAX:    duty_hi      = cfg_wdata[fdk_pkg::DUTY_W-1:0];
                    default: ;
                endcase
            end
            // Results are checked before this edge's input is predicted, so a result
            // that appears too early is not matched against its own expectation.
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[6:0], m_tdata[14:7], m_tdata[15], m_tdata[31:16]};
                if (expected_fan_q.size() == 0) begin
                    report_error($sformatf("result %h with nothing expected", m_tdata));
                end else begin
                    want = expected_fan_q.pop_front();
                    if (got.power_request != want.power_request)
                        report_error($sformatf("power_request %0d, expected %0d",
                                               got.power_request, want.power_request));
                    if (got.pwm_duty != want.pwm_duty)
                        report_error($sformatf("pwm_duty %0d, expected %0d",
                                               got.pwm_duty, want.pwm_duty));
                    if (got.kick_active != want.kick_active)
                        report_error($sformatf("kick_active %0d, expected %0d",
                                               got.kick_active, want.kick_active));
                    if (got.override_left != want.override_left)
                        report_error($sformatf("override_left %0d, expected %0d",
                                               got.override_left, want.override_left));
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == fdk_pkg::CMD_OVERRIDE) begin
                    level        = s_tdata[52:46];
                    manual_count = s_tdata[45:30];
                    manual_level = (level > fdk_pkg::FULL_PERCENT) ?
                                   fdk_pkg::FULL_PERCENT : level;
                end else begin
                    expected_fan_q.push_back(run_fan_tick(s_tdata[14:0], s_tdata[29:15]));
                end
            end
        end
        outstanding <= expected_fan_q.size();
    end

endmodule

// ===== dv/fan_drive_with_kick_start_core_test.sv =====
// Top of the fan drive testbench: clock, reset, stimulus, register setups and verdict.
module fan_drive_with_kick_start_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 6;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [fdk_pkg::S_TDATA_W-1:0]  s_tdata;
    logic                           s_tuser;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [fdk_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                           cfg_wr_en;
    logic [fdk_pkg::CFG_IDX_W-1:0]  cfg_addr;
    logic [fdk_pkg::CFG_W-1:0]      cfg_wdata;

    int outstanding;
    int fail_count;
    int cycles;

    int src_idle_pct = 0;
    int dst_idle_pct = 0;

    // Current setup as the stimulus sees it, used only to steer readings.
    int heater_min_now = 3000;
    int room_min_now   = 2000;
    int last_heater;
    int last_room;
    bit have_last = 1'b0;

    fan_drive_with_kick_start_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    fan_duty_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= dst_idle_pct);
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // One transfer on the s_ channel; tvalid stays high after it so back-to-back items flow.
    task automatic push_item(input fdk_pkg::cmd_t cmd, input int heater, input int room,
                             input int secs, input int pct);
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {3'b000, 7'(pct), 16'(secs), 15'(room), 15'(heater)};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_tick(input int heater, input int room);
        push_item(fdk_pkg::CMD_TICK, heater, room, $urandom_range(65535), $urandom_range(127));
    endtask

    task automatic send_override(input int secs, input int pct);
        push_item(fdk_pkg::CMD_OVERRIDE, $urandom, $urandom, secs, pct);
    endtask

    // Holds the sender off until every tick result has come out.
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic load_setup(input int heater_min, input int room_min,
                              input int duty_min, input int duty_max);
        wait_results_drained();
        // An override load leaves no result behind, so give the pipeline time to empty.
        repeat (SETTLE) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= fdk_pkg::REG_HEATER_MIN;
        cfg_wdata <= 15'(heater_min);
        @(posedge aclk);
        cfg_addr  <= fdk_pkg::REG_ROOM_MIN;
        cfg_wdata <= 15'(room_min);
        @(posedge aclk);
        cfg_addr  <= fdk_pkg::REG_PWM_MIN;
        cfg_wdata <= {7'($urandom), 8'(duty_min)};
        @(posedge aclk);
        cfg_addr  <= fdk_pkg::REG_PWM_MAX;
        cfg_wdata <= {7'($urandom), 8'(duty_max)};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        heater_min_now = 15'(heater_min) & 32'h7fff;
        heater_min_now = (heater_min_now > 16383) ? heater_min_now - 32768 : heater_min_now;
        room_min_now   = 15'(room_min) & 32'h7fff;
        room_min_now   = (room_min_now > 16383) ? room_min_now - 32768 : room_min_now;
        have_last      = 1'b0;
    endtask

    task automatic send_random_item();
        int pick;
        int secs;
        int roll;
        pick = $urandom_range(99);
        if (pick < 8) begin
            case ($urandom_range(3))
                0:       secs = 0;
                1, 2:    secs = $urandom_range(1, 6);
                default: secs = $urandom_range(65535);
            endcase
            send_override(secs, $urandom_range(127));
        end else begin
            // Repeated readings let a kick run out so the scaled duty shows.
            if (pick >= 50 || !have_last) begin
                roll = $urandom_range(99);
                if (roll < 85)
                    last_heater = heater_min_now + $urandom_range(3000);
                else if (roll < 95)
                    last_heater = heater_min_now - $urandom_range(1, 300);
                else
                    last_heater = $urandom_range(32767);
                roll = $urandom_range(99);
                if (roll < 70)
                    last_room = room_min_now - 130 + $urandom_range(160);
                else if (roll < 90)
                    last_room = $urandom_range(20500) - 5500;
                else
                    last_room = $urandom_range(32767);
                have_last = 1'b1;
            end
            send_tick(last_heater, last_room);
        end
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= fdk_pkg::CMD_TICK;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= fdk_pkg::REG_HEATER_MIN;
        cfg_wdata <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin src_idle_pct = 31; dst_idle_pct = 48; end
                1:       begin src_idle_pct = 48; dst_idle_pct = 31; end
                default: begin src_idle_pct = 0;  dst_idle_pct = 0;  end
            endcase
            for (int seg = 0; seg < 3; seg++) begin
                case (phase * 3 + seg)
                    0: begin
                        // Reset setup: heater floor 30.00, room floor 20.00, full duty span.
                        send_tick(2999, 0);        // heater just too cold
                        send_tick(3000, 1899);     // room below the full power band: kick
                        send_tick(3000, 1899);     // second kick tick
                        send_tick(3000, 1899);     // scaled full duty
                        send_tick(3000, 1900);     // band edge, same request, no kick
                        send_tick(3000, 1950);     // new request kicks
                        send_tick(3000, 1999);     // change during the kick is ignored
                        send_tick(3000, 1999);     // still differs after the kick: kicks again
                        send_tick(3000, 2000);     // room at the floor: request off, kick still running
                        send_tick(3000, 2001);     // room above the floor: off
                        send_tick(15000, -5500);
                        send_tick(-5500, -5500);
                        send_override(3, 127);     // percent saturates to full
                        send_tick(3000, 2500);
                        send_tick(3000, 2500);
                        send_tick(3000, 2500);
                        send_override(0, 50);      // zero length has no effect
                        send_tick(3000, 1960);
                        send_override(65535, 0);
                        send_tick(3000, 1960);
                        send_override(2, 37);      // replaces the long override
                        send_tick(16383, -16384);
                        send_tick(-16384, 16383);
                        send_tick(3000, 1990);
                        wait_results_drained();
                    end
                    1: load_setup(15000, 15000, 255, 0);
                    2: load_setup(-5500, -5400, 0, 255);
                    3: load_setup(0, 0, 0, 0);
                    4: load_setup(16383, -16384, 255, 255);
                    default: load_setup($urandom_range(20500) - 5500, $urandom_range(20400) - 5400,
                                        $urandom_range(255), $urandom_range(255));
                endcase
                repeat (56) begin
                    if ($urandom_range(39) == 0)
                        wait_results_drained();
                    send_random_item();
                end
            end
        end

        wait_results_drained();
        repeat (SETTLE) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
